// ===== design/can_frame_segmenter_top_assert.svh =====
// ----------------------------------------------------------------------------
// can frame segmenter assertion macros
// shared concurrent assertion shorthands, clocked on clk, disabled in rst
// ----------------------------------------------------------------------------
`ifndef CAN_FRAME_SEGMENTER_TOP_ASSERT_SVH
`define CAN_FRAME_SEGMENTER_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define CFS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define CFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/cfs_pkg.sv =====
// ----------------------------------------------------------------------------
// cfs_pkg
// shared types and constants of the can frame segmenter
// ----------------------------------------------------------------------------
package cfs_pkg;

  localparam int IdW       = 29;
  localparam int ByteW     = 8;
  localparam int LenW      = 4;
  localparam int PayloadW  = 64;
  localparam int MaxBytes  = 8;
  localparam int FirstBit  = 28;
  localparam int LastBit   = 20;

  localparam int FrameBytesDef = 8;
  localparam int QueueDepthDef = 2;

  typedef struct packed {
    logic [IdW-1:0]      id;
    logic [LenW-1:0]     length;
    logic [PayloadW-1:0] payload;
    logic                final_frame;
  } frame_t;

  // handshake signals between the front and the queue
  typedef struct packed {
    logic   push;
    frame_t frame;
  } push_t;

  // handshake signals between the queue and the back
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } head_t;

endpackage

// ===== design/cfs_front.sv =====
// ----------------------------------------------------------------------------
// cfs_front
// accepts bytes, packs them into the frame buffer and decides frame ends
// ----------------------------------------------------------------------------
`include "can_frame_segmenter_top_assert.svh"

module cfs_front #(
  parameter int FRAME_BYTES = cfs_pkg::FrameBytesDef
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [cfs_pkg::IdW-1:0]    message_id,
  input  logic [cfs_pkg::ByteW-1:0]  data_byte,
  input  logic                       byte_present,
  input  logic                       last_byte,
  output cfs_pkg::push_t             push_out
);

  logic [cfs_pkg::LenW-1:0]     gathered_count, gathered_count_next;
  logic [cfs_pkg::PayloadW-1:0] payload_buffer, payload_buffer_next;
  logic                         at_message_start, at_message_start_next;
  logic                         first_frame_pending, first_frame_pending_next;
  logic [cfs_pkg::IdW-1:0]      held_id, held_id_next;

  logic [cfs_pkg::IdW-1:0]      id_eff;
  logic [cfs_pkg::LenW-1:0]     cnt_eff, cnt_new;
  logic [cfs_pkg::PayloadW-1:0] buf_eff, buf_new;
  logic                         first_eff;
  logic                         emit, is_final;
  logic [cfs_pkg::LenW-1:0]     out_len;
  logic [cfs_pkg::PayloadW-1:0] out_buf;
  logic [cfs_pkg::IdW-1:0]      out_id;

  always_comb begin
    id_eff    = at_message_start ? message_id : held_id;
    cnt_eff   = at_message_start ? '0 : gathered_count;
    buf_eff   = at_message_start ? '0 : payload_buffer;
    first_eff = at_message_start | first_frame_pending;

    // byte lands at lane cnt_eff, little-endian
    buf_new = buf_eff;
    cnt_new = cnt_eff;
    if (cnt_eff < cfs_pkg::LenW'(cfs_pkg::MaxBytes)) begin
      buf_new = buf_eff | (cfs_pkg::PayloadW'(data_byte) << {cnt_eff[2:0], 3'b000});
      cnt_new = cnt_eff + 1'b1;
    end

    if (!byte_present) begin
      // no byte: flush what is held as the final frame
      emit     = 1'b1;
      is_final = 1'b1;
      out_len  = cnt_eff;
      out_buf  = buf_eff;
    end else begin
      emit     = last_byte || (cnt_new >= cfs_pkg::LenW'(FRAME_BYTES));
      is_final = last_byte;
      out_len  = cnt_new;
      out_buf  = buf_new;
    end

    out_id = id_eff;
    if (first_eff) out_id[cfs_pkg::FirstBit] = 1'b1;
    if (is_final)  out_id[cfs_pkg::LastBit]  = 1'b1;
  end

  always_comb begin
    held_id_next             = id_eff;
    if (emit) begin
      gathered_count_next      = '0;
      payload_buffer_next      = '0;
      first_frame_pending_next = is_final;
      at_message_start_next    = is_final;
    end else begin
      gathered_count_next      = cnt_new;
      payload_buffer_next      = buf_new;
      first_frame_pending_next = first_eff;
      at_message_start_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gathered_count      <= '0;
      payload_buffer      <= '0;
      at_message_start    <= 1'b1;
      first_frame_pending <= 1'b1;
      held_id             <= '0;
    end else if (accept) begin
      gathered_count      <= gathered_count_next;
      payload_buffer      <= payload_buffer_next;
      at_message_start    <= at_message_start_next;
      first_frame_pending <= first_frame_pending_next;
      held_id             <= held_id_next;
    end
  end

  assign push_out.push              = accept && emit;
  assign push_out.frame.id          = out_id;
  assign push_out.frame.length      = out_len;
  assign push_out.frame.payload     = out_buf;
  assign push_out.frame.final_frame = is_final;

  `CFS_ASSERT_NEXT(a_final_reopens, accept && emit && is_final, at_message_start,
                   "final frame did not reopen message")
  `CFS_ASSERT_ALWAYS(a_len_bound, gathered_count < cfs_pkg::LenW'(FRAME_BYTES),
                     "held byte count reached frame size")

endmodule

// ===== design/cfs_queue.sv =====
// ----------------------------------------------------------------------------
// cfs_queue
// short frame queue between the packing front and the output stage
// ----------------------------------------------------------------------------
`include "can_frame_segmenter_top_assert.svh"

module cfs_queue #(
  parameter int DEPTH = cfs_pkg::QueueDepthDef
) (
  input  logic           clk,
  input  logic           rst,
  input  cfs_pkg::push_t push_in,
  input  logic           pop,
  output logic           full,
  output cfs_pkg::head_t head
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  cfs_pkg::frame_t entries [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_pop;

  assign do_pop = pop && (count != '0);
  assign full   = (count == CntW'(DEPTH));

  always_ff @(posedge clk) begin
    if (push_in.push) entries[wr_ptr] <= push_in.frame;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_in.push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push_in.push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != '0);
  assign head.frame = entries[rd_ptr];

  `CFS_ASSERT_ALWAYS(a_no_overflow, !(push_in.push && full), "push into full queue")
  `CFS_ASSERT_NEXT(a_push_seen, push_in.push && !do_pop, count != '0,
                   "queue empty right after push")

endmodule

// ===== design/cfs_back.sv =====
// ----------------------------------------------------------------------------
// cfs_back
// output register that drives the frame stream from the queue head
// ----------------------------------------------------------------------------
module cfs_back (
  input  logic           clk,
  input  logic           rst,
  input  cfs_pkg::head_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output cfs_pkg::frame_t out_frame
);

  logic load;

  assign load = head.valid && (!out_valid || out_ready);
  assign pop  = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_frame <= head.frame;
  end

endmodule

// ===== design/can_frame_segmenter_top.sv =====
// ----------------------------------------------------------------------------
// can_frame_segmenter_top
// splits a byte stream message into extended can frames of up to eight bytes
// ----------------------------------------------------------------------------
// usage:
//   s_* channel takes one item per byte: tdata carries the 29-bit identifier
//   (used on the first item of a message) and the byte, tuser says a byte is
//   present, tlast marks the final byte. an item without a byte ends the
//   message; at message start it gives one empty first-and-last frame.
//   m_* channel gives one frame per full group of FRAME_BYTES bytes or per
//   message end: identifier with bit 28 on the first frame and bit 20 on the
//   last, length 0..8, payload little-endian with unused bytes zero, tlast on
//   the frame that ends the message.
//   throughput: one item per cycle, sustained while the queue has room; the packing
//   register in the front takes a byte every cycle that s_tready is high and the
//   queue plus output register move one frame per cycle while m_tready is high.
//   a closed frame passes from the queue into the output register before it appears.
//   reset: rst (synchronous) empties the queue and output register and opens
//   a new message. when the receiver stalls, the queue fills and s_tready
//   drops only once QUEUE_DEPTH frames wait behind the output register.
// ----------------------------------------------------------------------------
module can_frame_segmenter_top #(
  parameter int FRAME_BYTES = cfs_pkg::FrameBytesDef,
  parameter int QUEUE_DEPTH = cfs_pkg::QueueDepthDef
) (
  input  logic         clk,
  input  logic         rst,
  // input item stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // message_id [28:0], data_byte [36:29], zero pad
  input  logic         s_tuser,   // byte_present
  input  logic         s_tlast,   // last_byte
  // output frame stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // frame_id [28:0], frame_length [32:29],
                                  // frame_payload [96:33], zero pad
  output logic         m_tlast    // final_frame
);

  cfs_pkg::push_t  push;
  cfs_pkg::head_t  head;
  cfs_pkg::frame_t out_frame;
  logic            full;
  logic            pop;
  logic            accept;

  // the front only stalls when the queue has no room
  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  cfs_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .message_id   (s_tdata[28:0]),
    .data_byte    (s_tdata[36:29]),
    .byte_present (s_tuser),
    .last_byte    (s_tlast),
    .push_out     (push)
  );

  cfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_in (push),
    .pop     (pop),
    .full    (full),
    .head    (head)
  );

  cfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_frame (out_frame)
  );

  // pack the frame fields, lowest field first
  assign m_tdata = {7'b0, out_frame.payload, out_frame.length, out_frame.id};
  assign m_tlast = out_frame.final_frame;

endmodule
